// ----- hw/rtl/mwe_pkg.sv -----
// Package for the Microwire EEPROM master: item types, sequencer step codes,
// command kinds and command geometry constants. No dependencies.
package mwe_pkg;

  localparam int ADDRESS_BITS = 8;
  localparam int CMD_W        = ADDRESS_BITS + 11;
  localparam int LEN_W        = $clog2(CMD_W + 1);
  localparam int POS_W        = $clog2(CMD_W);

  localparam logic [LEN_W-1:0] LEN_EW = LEN_W'(ADDRESS_BITS + 2);
  localparam logic [LEN_W-1:0] LEN_RD = LEN_W'(ADDRESS_BITS + 3);
  localparam logic [LEN_W-1:0] LEN_WR = LEN_W'(ADDRESS_BITS + 11);

  localparam logic [LEN_W-1:0] RX_BITS = LEN_W'(8);

  // Sequencer steps.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BEGIN  = 3'd1;
  localparam logic [2:0] ST_BITS   = 3'd2;
  localparam logic [2:0] ST_EWTAIL = 3'd3;
  localparam logic [2:0] ST_WTAIL  = 3'd4;
  localparam logic [2:0] ST_WAIT   = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;
  localparam logic [2:0] ST_RX     = 3'd7;

  // Command kinds.
  localparam logic [1:0] K_EWEN   = 2'd0;
  localparam logic [1:0] K_ACCESS = 2'd1;
  localparam logic [1:0] K_EWDS   = 2'd2;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic       start_req;
    logic       func;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       data_out_pin;
  } in_item_t;

  typedef struct packed {
    logic       chip_select;
    logic       serial_clock;
    logic       serial_data_in;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_item_t;

  // Pin levels ordered {cs, clk, di}.
  typedef logic [2:0] pins_t;

endpackage

// ----- hw/rtl/mwe_seq.sv -----
// Pin-level sequencer of the Microwire EEPROM master: holds the access state
// and computes the next state and the pin levels for one tick. Uses mwe_pkg.
module mwe_seq
  import mwe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  logic [7:0] ticks_per_phase,
  output out_item_t result
);

  logic [2:0]       step_r, step_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [7:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] bit_r, bit_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       cap_r, cap_nxt;
  logic             func_r, func_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [7:0]       result_r, result_nxt;
  pins_t            idle_pins_r, idle_pins_nxt;
  logic             done;
  logic             launch;
  logic [1:0]       launch_kind;
  logic [7:0]       limit;
  pins_t            pins;

  // Pin levels shown in a given state.
  function automatic pins_t pins_of(input logic [2:0] st, input logic [1:0] sp,
                                    input logic [LEN_W-1:0] bi,
                                    input logic [LEN_W-1:0] ln,
                                    input logic [CMD_W-1:0] cw,
                                    input pins_t ip);
    logic [LEN_W-1:0] pos;
    logic             b;
    pins_t            p;
    pos = ln - bi - LEN_W'(1);
    b   = (bi < ln) ? cw[pos[POS_W-1:0]] : 1'b0;
    unique case (st)
      ST_BEGIN:  p = (sp == 2'd0) ? 3'b101 : (sp == 2'd1) ? 3'b111 : 3'b100;
      ST_BITS:   p = {1'b1, sp == 2'd1, b};
      ST_EWTAIL: p = (sp == 2'd0) ? 3'b110 : 3'b000;
      ST_WTAIL:  p = (sp == 2'd0) ? 3'b010 : 3'b000;
      ST_WAIT:   p = 3'b110;
      ST_END:    p = 3'b010;
      ST_RX:     p = (sp == 2'd0) ? 3'b100 : 3'b110;
      default:   p = ip;
    endcase
    return p;
  endfunction

  assign limit = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;

  always_comb begin
    step_nxt      = step_r;
    sub_nxt       = sub_r;
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    kind_nxt      = kind_r;
    cap_nxt       = cap_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    result_nxt    = result_r;
    idle_pins_nxt = idle_pins_r;
    done          = 1'b0;
    launch        = 1'b0;
    launch_kind   = K_ACCESS;

    if (step_r == ST_IDLE) begin
      if (item.start_req) begin
        func_nxt    = item.func;
        addr_nxt    = item.address;
        data_nxt    = item.write_data;
        launch      = 1'b1;
        launch_kind = (item.func == FUNC_WRITE) ? K_EWEN : K_ACCESS;
        phase_nxt   = 8'd1;
      end
    end else if (step_r == ST_WAIT) begin
      if (item.data_out_pin) begin
        step_nxt  = ST_END;
        sub_nxt   = 2'd0;
        phase_nxt = 8'd1;
      end
    end else if (phase_r < limit) begin
      phase_nxt = phase_r + 8'd1;
    end else begin
      phase_nxt = 8'd1;
      case (step_r)
        ST_BEGIN: begin
          if (sub_r < 2'd2) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            step_nxt = ST_BITS;
            sub_nxt  = 2'd0;
            bit_nxt  = '0;
          end
        end
        ST_BITS: begin
          if (sub_r < 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            sub_nxt = 2'd0;
            if ({1'b0, bit_r} + (LEN_W+1)'(1) < {1'b0, len_r}) begin
              bit_nxt = bit_r + LEN_W'(1);
            end else begin
              bit_nxt = '0;
              if (kind_r == K_ACCESS) begin
                step_nxt = (func_r == FUNC_WRITE) ? ST_WTAIL : ST_RX;
              end else begin
                step_nxt = ST_EWTAIL;
              end
            end
          end
        end
        ST_EWTAIL: begin
          if (sub_r == 2'd0) begin
            sub_nxt = 2'd1;
          end else if (kind_r == K_EWEN) begin
            launch      = 1'b1;
            launch_kind = K_ACCESS;
          end else begin
            done = 1'b1;
          end
        end
        ST_WTAIL: begin
          if (sub_r == 2'd0) begin
            sub_nxt = 2'd1;
          end else begin
            step_nxt = ST_WAIT;
            sub_nxt  = 2'd0;
          end
        end
        ST_END: begin
          if (func_r == FUNC_WRITE) begin
            launch      = 1'b1;
            launch_kind = K_EWDS;
          end else begin
            done = 1'b1;
          end
        end
        ST_RX: begin
          if (sub_r == 2'd0) begin
            sub_nxt = 2'd1;
          end else if (bit_r < RX_BITS) begin
            cap_nxt = {cap_r[6:0], item.data_out_pin};
            bit_nxt = bit_r + LEN_W'(1);
            sub_nxt = 2'd0;
          end else begin
            step_nxt = ST_END;
            sub_nxt  = 2'd0;
            bit_nxt  = '0;
          end
        end
        default: begin
          step_nxt = ST_IDLE;
        end
      endcase
    end

    if (launch) begin
      kind_nxt = launch_kind;
      if (launch_kind == K_EWEN) begin
        len_nxt = LEN_EW;
        cmd_nxt = CMD_W'(3) << (ADDRESS_BITS - 2);
      end else if (launch_kind == K_EWDS) begin
        len_nxt = LEN_EW;
        cmd_nxt = '0;
      end else if (func_nxt == FUNC_WRITE) begin
        len_nxt = LEN_WR;
        cmd_nxt = {3'b010, ADDRESS_BITS'(addr_nxt), data_nxt};
      end else begin
        len_nxt = LEN_RD;
        cmd_nxt = CMD_W'({3'b100, ADDRESS_BITS'(addr_nxt)});
      end
      step_nxt = ST_BEGIN;
      sub_nxt  = 2'd0;
      bit_nxt  = '0;
    end

    // The idle pins keep the levels of the final phase of the access.
    if (done) begin
      idle_pins_nxt = pins_of(step_r, sub_r, bit_r, len_r, cmd_r, idle_pins_r);
      if (func_r == FUNC_READ) begin
        result_nxt = cap_r;
      end
      step_nxt = ST_IDLE;
      sub_nxt  = 2'd0;
      bit_nxt  = '0;
    end

    pins = pins_of(step_nxt, sub_nxt, bit_nxt, len_nxt, cmd_nxt, idle_pins_nxt);

    result.chip_select    = pins[2];
    result.serial_clock   = pins[1];
    result.serial_data_in = pins[0];
    result.busy_res       = (step_nxt != ST_IDLE);
    result.done_res       = done;
    result.read_data      = result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      sub_r       <= 2'd0;
      phase_r     <= 8'd0;
      bit_r       <= '0;
      len_r       <= '0;
      cmd_r       <= '0;
      kind_r      <= K_EWEN;
      cap_r       <= 8'd0;
      func_r      <= 1'b0;
      addr_r      <= 8'd0;
      data_r      <= 8'd0;
      result_r    <= 8'd0;
      idle_pins_r <= 3'b000;
    end else if (step_en) begin
      step_r      <= step_nxt;
      sub_r       <= sub_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      len_r       <= len_nxt;
      cmd_r       <= cmd_nxt;
      kind_r      <= kind_nxt;
      cap_r       <= cap_nxt;
      func_r      <= func_nxt;
      addr_r      <= addr_nxt;
      data_r      <= data_nxt;
      result_r    <= result_nxt;
      idle_pins_r <= idle_pins_nxt;
    end
  end

endmodule

// ----- hw/rtl/microwire_eeprom_master.sv -----
// Microwire EEPROM master top level: input register, sequencer, result
// register and the phase length register. Uses mwe_pkg and mwe_seq.
// A result item is the sequencer's answer to the item in the input register.
// Throughput: one item per cycle; the input register and the result register
// form a two-deep pipeline, so input is stalled only while the result stalls.
// Reset (synchronous, rst_n low): pipeline empty, sequencer idle, all pins
// low, phase length 4.
module microwire_eeprom_master
  import mwe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       s1_adv;
  logic       in_acc;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  seq_result;
  logic [7:0] ticks_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  mwe_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (s1_adv),
    .item            (s1_item_r),
    .ticks_per_phase (ticks_r),
    .result          (seq_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ticks_r     <= 8'd4;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/mwe_checker.sv -----
// Port-level checker for the Microwire EEPROM master, bound to the top level.
// Uses mwe_pkg for the item types.
module mwe_checker
  import mwe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic       out_acc;
  logic       seen_r;
  logic [7:0] last_read_r;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_acc) begin
      seen_r <= 1'b1;
    end
    if (out_acc) begin
      last_read_r <= out_item.read_data;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A completed access leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done shown while still busy");

  // While idle the chip is deselected and data-in is low.
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.busy_res |-> !out_item.chip_select && !out_item.serial_data_in)
    else $error("idle pins not parked");

  // The read byte only changes on an item that completes an access.
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && !out_item.done_res |-> out_item.read_data == last_read_r)
    else $error("read data changed without a completed access");

endmodule

bind microwire_eeprom_master mwe_checker u_mwe_checker (.*);

// ----- tb/microwire_eeprom_master_test.sv -----
// Self-checking testbench for the Microwire EEPROM master: drives directed and
// random tick items through the valid/stall channels and checks every result item.
// Depends on mwe_pkg and microwire_eeprom_master.
module microwire_eeprom_master_test
  import mwe_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 300;

  // How often data-out is high within a stretch of generated ticks.
  localparam int DOUT_LOW  = 0;
  localparam int DOUT_RARE = 1;
  localparam int DOUT_HALF = 2;
  localparam int DOUT_HIGH = 3;

  localparam pins_t PIN_CS  = 3'b100;
  localparam pins_t PIN_CLK = 3'b010;
  localparam pins_t PIN_DI  = 3'b001;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  in_item_t  pending_ticks[$];
  out_item_t expected_pins[$];
  out_item_t wanted;
  int        mismatches = 0;
  int        send_gap = 0;
  int        send_calm = 0;
  int        recv_wait = 0;
  int        recv_calm = 0;
  int        hold_asks = 0;
  int        holds_done = 0;

  // Sequencer shadow state.
  logic [7:0]  phase_len_cfg = 8'd4;
  logic [2:0]  seq_step = ST_IDLE;
  int          phase_ticks = 0;
  int          sub_phase = 0;
  int          bit_pos = 0;
  int          cmd_len = 0;
  logic [31:0] cmd_bits = '0;
  logic [1:0]  cmd_kind = K_EWEN;
  logic [7:0]  rx_shift = '0;
  logic        hold_func = 1'b0;
  logic [7:0]  hold_addr = '0;
  logic [7:0]  hold_wdata = '0;
  logic [7:0]  read_byte = '0;
  pins_t       idle_pins = '0;
  logic        done_now = 1'b0;

  microwire_eeprom_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic pins_t pin_levels();
    int   pos;
    logic b;
    pos = cmd_len - 1 - bit_pos;
    b = (bit_pos < cmd_len && pos >= 0 && pos <= 31) ? cmd_bits[pos] : 1'b0;
    case (seq_step)
      ST_BEGIN: begin
        if (sub_phase == 0) return PIN_CS | PIN_DI;
        if (sub_phase == 1) return PIN_CS | PIN_CLK | PIN_DI;
        return PIN_CS;
      end
      ST_BITS:   return PIN_CS | (sub_phase == 1 ? PIN_CLK : 3'b000) | {2'b00, b};
      ST_EWTAIL: return sub_phase == 0 ? (PIN_CS | PIN_CLK) : 3'b000;
      ST_WTAIL:  return sub_phase == 0 ? PIN_CLK : 3'b000;
      ST_WAIT:   return PIN_CS | PIN_CLK;
      ST_END:    return PIN_CLK;
      ST_RX:     return sub_phase == 0 ? PIN_CS : (PIN_CS | PIN_CLK);
      default:   return idle_pins;
    endcase
  endfunction

  function automatic void load_command(logic [1:0] kind);
    logic [31:0] amask;
    logic [31:0] addr;
    amask = (32'd1 << ADDRESS_BITS) - 32'd1;
    addr = {24'd0, hold_addr} & amask;
    cmd_kind = kind;
    if (kind == K_EWEN) begin
      cmd_len = ADDRESS_BITS + 2;
      cmd_bits = 32'd3 << (ADDRESS_BITS - 2);
    end else if (kind == K_EWDS) begin
      cmd_len = ADDRESS_BITS + 2;
      cmd_bits = '0;
    end else if (hold_func == FUNC_WRITE) begin
      cmd_len = ADDRESS_BITS + 11;
      cmd_bits = (((32'd2 << ADDRESS_BITS) | addr) << 8) | {24'd0, hold_wdata};
    end else begin
      cmd_len = ADDRESS_BITS + 3;
      cmd_bits = (32'd4 << ADDRESS_BITS) | addr;
    end
    seq_step = ST_BEGIN;
    sub_phase = 0;
    bit_pos = 0;
  endfunction

  function automatic void end_access();
    idle_pins = pin_levels();
    if (hold_func == FUNC_READ) read_byte = rx_shift;
    seq_step = ST_IDLE;
    sub_phase = 0;
    bit_pos = 0;
    done_now = 1'b1;
  endfunction

  // One clock tick of the sequencer; returns the pins and flags after it.
  function automatic out_item_t predict_tick(in_item_t t);
    int        limit;
    pins_t     p;
    out_item_t r;
    limit = (phase_len_cfg == 8'd0) ? 1 : int'(phase_len_cfg);
    done_now = 1'b0;
    if (seq_step == ST_IDLE) begin
      if (t.start_req) begin
        hold_func = t.func;
        hold_addr = t.address;
        hold_wdata = t.write_data;
        load_command(t.func == FUNC_WRITE ? K_EWEN : K_ACCESS);
        phase_ticks = 1;
      end
    end else if (seq_step == ST_WAIT) begin
      if (t.data_out_pin) begin
        seq_step = ST_END;
        sub_phase = 0;
        phase_ticks = 1;
      end
    end else if (phase_ticks < limit) begin
      phase_ticks++;
    end else begin
      case (seq_step)
        ST_BEGIN: begin
          if (sub_phase < 2) begin
            sub_phase++;
          end else begin
            seq_step = ST_BITS;
            sub_phase = 0;
            bit_pos = 0;
          end
        end
        ST_BITS: begin
          if (sub_phase < 3) begin
            sub_phase++;
          end else begin
            sub_phase = 0;
            if (bit_pos + 1 < cmd_len) begin
              bit_pos++;
            end else begin
              bit_pos = 0;
              if (cmd_kind == K_ACCESS)
                seq_step = (hold_func == FUNC_WRITE) ? ST_WTAIL : ST_RX;
              else
                seq_step = ST_EWTAIL;
            end
          end
        end
        ST_EWTAIL: begin
          if (sub_phase == 0) sub_phase = 1;
          else if (cmd_kind == K_EWEN) load_command(K_ACCESS);
          else end_access();
        end
        ST_WTAIL: begin
          if (sub_phase == 0) begin
            sub_phase = 1;
          end else begin
            seq_step = ST_WAIT;
            sub_phase = 0;
          end
        end
        ST_END: begin
          if (hold_func == FUNC_WRITE) load_command(K_EWDS);
          else end_access();
        end
        ST_RX: begin
          if (sub_phase == 0) begin
            sub_phase = 1;
          end else if (bit_pos < 8) begin
            // Data-out is taken on the last tick of each clock-high phase.
            rx_shift = {rx_shift[6:0], t.data_out_pin};
            bit_pos++;
            sub_phase = 0;
          end else begin
            seq_step = ST_END;
            sub_phase = 0;
            bit_pos = 0;
          end
        end
        default: seq_step = ST_IDLE;
      endcase
      phase_ticks = 1;
    end
    p = pin_levels();
    r.chip_select = p[2];
    r.serial_clock = p[1];
    r.serial_data_in = p[0];
    r.busy_res = (seq_step != ST_IDLE);
    r.done_res = done_now;
    r.read_data = read_byte;
    return r;
  endfunction

  function automatic in_item_t random_tick(int dout_mode);
    in_item_t t;
    t.start_req = ($urandom_range(0, 2) == 0);
    t.func = 1'($urandom_range(0, 1));
    t.address = 8'($urandom_range(0, 255));
    t.write_data = 8'($urandom_range(0, 255));
    case (dout_mode)
      DOUT_LOW:  t.data_out_pin = 1'b0;
      DOUT_RARE: t.data_out_pin = ($urandom_range(0, 7) == 0);
      DOUT_HALF: t.data_out_pin = 1'($urandom_range(0, 1));
      default:   t.data_out_pin = 1'b1;
    endcase
    return t;
  endfunction

  function automatic in_item_t make_tick(logic start, logic func, logic [7:0] addr,
                                         logic [7:0] wdata, logic dout);
    in_item_t t;
    t.start_req = start;
    t.func = func;
    t.address = addr;
    t.write_data = wdata;
    t.data_out_pin = dout;
    return t;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  task automatic queue_ticks(int n);
    int mode;
    mode = DOUT_HALF;
    for (int i = 0; i < n; i++) begin
      // Data-out behavior changes in stretches so ready waits vary in length.
      if (i % 16 == 0) mode = $urandom_range(DOUT_LOW, DOUT_HIGH);
      pending_ticks.push_back(random_tick(mode));
    end
  endtask

  // Sampled on the falling edge so that every update of the rising edge is seen.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_pins.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_phase_len(logic [7:0] ticks);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    phase_len_cfg = ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: one item per handshake, with a random pause after each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_pins.push_back(predict_tick(in_item));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_item <= pending_ticks.pop_front();
          in_valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            send_calm = $urandom_range(10, 40);
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result item and stalls at random afterwards.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          mismatches++;
          $display("%0t: result item %h with none expected", $time, out_item);
        end else begin
          wanted = expected_pins.pop_front();
          check_field("chip_select", int'(wanted.chip_select),
                      int'(out_item.chip_select));
          check_field("serial_clock", int'(wanted.serial_clock),
                      int'(out_item.serial_clock));
          check_field("serial_data_in", int'(wanted.serial_data_in),
                      int'(out_item.serial_data_in));
          check_field("busy_res", int'(wanted.busy_res), int'(out_item.busy_res));
          check_field("done_res", int'(wanted.done_res), int'(out_item.done_res));
          check_field("read_data", int'(wanted.read_data), int'(out_item.read_data));
        end
      end
      if (holds_done != hold_asks) begin
        holds_done++;
        recv_wait = LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_calm = $urandom_range(10, 40);
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 9);
        end
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a read of the top address at the reset phase length, then
    // requests with extreme fields that arrive while busy and must be ignored.
    pending_ticks.push_back(make_tick(1'b1, FUNC_READ, 8'hFF, 8'h00, 1'b0));
    for (int i = 0; i < 10; i++)
      pending_ticks.push_back(make_tick(1'b1, FUNC_WRITE, 8'h00, 8'hFF, 1'b1));
    for (int i = 0; i < 12; i++)
      pending_ticks.push_back(make_tick(1'b0, i[0], 8'h00, 8'h00, i[0]));
    wait_drained();

    set_phase_len(8'd1);
    queue_ticks(600);
    wait_drained();

    // A phase length of zero behaves as one.
    set_phase_len(8'd0);
    queue_ticks(300);
    wait_drained();

    // The longest phase, then a short one while an access is still running.
    set_phase_len(8'd255);
    queue_ticks(150);
    wait_drained();
    set_phase_len(8'd2);
    queue_ticks(400);
    wait_drained();

    // The receiver holds off long enough for the input side to back up.
    set_phase_len(8'd3);
    hold_asks++;
    queue_ticks(250);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
